@@ hw/rtl/bf3_pkg.sv @@
package bf3_pkg;

  // Frame size limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // Field and register widths
  localparam int unsigned PixW  = 8;
  localparam int unsigned CfgW  = 11;
  localparam int unsigned CfgIdxW = 1;

  // Line store address and counter widths
  localparam int unsigned AddrW = $clog2(MaxWidth);
  localparam int unsigned DimW  = $clog2(MaxWidth + 1);
  localparam int unsigned HgtW  = $clog2(MaxHeight + 1);
  localparam int unsigned RowW  = $clog2(MaxHeight + 3);
  localparam int unsigned ORowW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;

  // One line store word holds the row two above (high) and the row above (low)
  localparam int unsigned LineW = 2 * PixW;

  // Neighborhood sum and divide by nine through a reciprocal multiply
  localparam int unsigned SumW     = $clog2(9 * (2 ** PixW - 1) + 1);
  localparam int unsigned Div9Shft = SumW + 3;
  localparam int unsigned Div9Mult = (2 ** Div9Shft) / 9 + 1;
  localparam int unsigned MulW     = SumW + Div9Shft;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  // Control carried by an item from acceptance into the window stage
  typedef struct packed {
    logic             emit;
    logic             frame_end;
    logic             skip_left;
    logic             skip_right;
    logic             row_ge1;
    logic             row_ge2;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  pixel;
  } s1_ctrl_t;

endpackage

@@ hw/rtl/bf3_ram.sv @@
module bf3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/box_filter_3x3_zero_pad_core.sv @@
// 3x3 mean filter with a one-pixel zero border. Pixels enter in raster order
// and each image pixel gets floor(sum of its 3x3 neighborhood / 9), with
// neighbors outside the image taken as zero. Results lag the input by one row
// plus one pixel, so after the last pixel of a frame send image_width + 1
// transfers with tuser set to flush the rest; tlast marks the last result.
// The block takes one transfer per clock unless the output stalls, and a
// transfer's result is loaded into the output register as the item leaves
// the window stage: the line store (a 1024 x 16 two-port RAM, one word per
// column holding the two rows above) is read at the accepting edge together
// with the item register, and the window stage then does window update, sum
// and divide. The line store needs no clearing pass: rows above the first
// row of a frame are forced to zero, so stale contents are never used. Writing
// image_width or image_height restarts the frame; write them only while idle.
module box_filter_3x3_zero_pad_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [bf3_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bf3_pkg::CfgW-1:0]       cfg_wdata_i,
  // Pixel input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bf3_pkg::PixW-1:0]       s_axis_tdata,   // [7:0] pixel
  input  logic                           s_axis_tuser,   // [0] past_end
  // Mean output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bf3_pkg::PixW-1:0]       m_axis_tdata,   // [7:0] mean_value
  output logic                           m_axis_tlast    // frame_end
);

  import bf3_pkg::*;

  // Configuration and derived frame size
  logic [CfgW-1:0]  width_q, height_q;
  logic [DimW-1:0]  w_eff;
  logic [HgtW-1:0]  h_eff;

  // Position counters
  logic [AddrW-1:0] in_col_q, in_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d;
  logic [AddrW-1:0] out_col_q, out_col_d;
  logic [ORowW-1:0] out_row_q, out_row_d;

  // Input side
  logic             in_acc, in_drop, in_take;
  logic             row_ge_h, col_last, out_col_last;
  s1_ctrl_t         s1_d;

  // Window stage
  logic             s1_valid_q;
  s1_ctrl_t         s1_q;
  logic             s1_adv;
  logic             fwd_valid_q;
  logic [LineW-1:0] fwd_data_q;
  logic [LineW-1:0] ram_rdata, line_word, line_wdata;
  logic [PixW-1:0]  up, up2;
  logic [PixW-1:0]  win_q [3][3];
  logic [PixW-1:0]  new_col [3];
  logic [SumW-1:0]  sum;
  logic [MulW-1:0]  prod;

  // Output register
  logic             out_valid_q;
  logic [PixW-1:0]  out_data_q;
  logic             out_last_q;
  logic             out_can_load, out_load;

  // Clamp the size registers to the supported range
  always_comb begin
    if (width_q == '0) begin
      w_eff = DimW'(1);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = DimW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HgtW'(1);
    end else if (32'(height_q) > MaxHeight) begin
      h_eff = HgtW'(MaxHeight);
    end else begin
      h_eff = HgtW'(height_q);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(640);
      height_q <= CfgW'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth:  width_q  <= cfg_wdata_i;
        CfgImageHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: stall only when a result waits and the window stage is full
  assign out_can_load  = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && (!s1_q.emit || out_can_load);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  // Drop a flush transfer that arrives before any pixel of the frame
  assign in_drop = s_axis_tuser && (in_row_q == '0) && (in_col_q == '0);
  assign in_take = in_acc && !in_drop;

  assign row_ge_h     = 32'(in_row_q) >= 32'(h_eff);
  assign col_last     = 32'(in_col_q) + 32'd1 >= 32'(w_eff);
  assign out_col_last = 32'(out_col_q) + 32'd1 >= 32'(w_eff);

  // Decode the accepted item and advance the position counters
  always_comb begin
    s1_d.pixel      = (s_axis_tuser || row_ge_h) ? '0 : s_axis_tdata;
    s1_d.addr       = in_col_q;
    s1_d.row_ge1    = in_row_q >= RowW'(1);
    s1_d.row_ge2    = in_row_q >= RowW'(2);
    s1_d.skip_right = in_col_q == '0;
    s1_d.skip_left  = (in_col_q == AddrW'(1)) || ((in_col_q == '0) && (w_eff == DimW'(1)));
    s1_d.emit       = (s1_d.row_ge2 || ((in_row_q == RowW'(1)) && (in_col_q != '0)))
                      && (32'(out_row_q) < 32'(h_eff));
    s1_d.frame_end  = (32'(out_row_q) + 32'd1 >= 32'(h_eff)) && out_col_last;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_we_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (in_take) begin
      if (col_last) begin
        in_col_d = '0;
        if (32'(in_row_q) < 32'(h_eff) + 32'd2) begin
          in_row_d = in_row_q + RowW'(1);
        end
      end else begin
        in_col_d = in_col_q + AddrW'(1);
      end
      if (s1_d.emit) begin
        if (s1_d.frame_end) begin
          out_col_d = '0;
          out_row_d = '0;
          in_col_d  = '0;
          in_row_d  = '0;
        end else if (out_col_last) begin
          out_col_d = '0;
          out_row_d = out_row_q + ORowW'(1);
        end else begin
          out_col_d = out_col_q + AddrW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // Line store: read at acceptance, write back when the item leaves the stage
  bf3_ram #(
    .Width (LineW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_q.addr),
    .wdata_i (line_wdata),
    .re_i    (in_take),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  // Window stage control and same-column forwarding (one-pixel-wide rows)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q  <= 1'b1;
      fwd_valid_q <= s1_adv && (s1_q.addr == in_col_q);
    end else if (s1_adv) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q       <= s1_d;
      fwd_data_q <= line_wdata;
    end
  end

  // Rows above, zero above the top of the image
  assign line_word  = fwd_valid_q ? fwd_data_q : ram_rdata;
  assign up         = s1_q.row_ge1 ? line_word[PixW-1:0] : '0;
  assign up2        = s1_q.row_ge2 ? line_word[LineW-1:PixW] : '0;
  assign line_wdata = {line_word[PixW-1:0], s1_q.pixel};

  assign new_col[0] = up2;
  assign new_col[1] = up;
  assign new_col[2] = s1_q.pixel;

  // Shift the window one column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
        win_q[r][2] <= new_col[r];
      end
    end
  end

  // Sum the shifted window, leaving out columns past the row edges
  always_comb begin
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      if (!s1_q.skip_left) begin
        sum = sum + SumW'(win_q[r][1]);
      end
      sum = sum + SumW'(win_q[r][2]);
      if (!s1_q.skip_right) begin
        sum = sum + SumW'(new_col[r]);
      end
    end
  end

  // Divide by nine: multiply by the rounded-up reciprocal and shift
  assign prod = MulW'(sum) * MulW'(Div9Mult);

  // Output register
  assign out_load = s1_adv && s1_q.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= prod[Div9Shft +: PixW];
      out_last_q <= s1_q.frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Input column stays inside the row
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(in_col_q) < 32'(w_eff))
    else $error("input column past row end");

  // Output row stays inside the frame
  a_out_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(out_row_q) < 32'(h_eff))
    else $error("output row past frame end");

  // Input stalls only behind a waiting result with a result-bearing item staged
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_valid_q && s1_q.emit && out_valid_q && !m_axis_tready)
    else $error("input stalled without cause");

  // Forwarded line data belongs to a staged item
  a_fwd_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> s1_valid_q)
    else $error("forwarded line data without staged item");

endmodule

@@ sim/box_filter_3x3_zero_pad_core_test.sv @@
module box_filter_3x3_zero_pad_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bf3_pkg::*;

  localparam int unsigned RandomItems = 500;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned SettleWait  = 8;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ReportLimit = 100;

  typedef struct packed {
    logic [PixW-1:0] mean;
    logic            last;
  } mean_result_t;

  // Tracks frame position, line stores and window; predicts each mean
  class mean_tracker;
    logic [CfgW-1:0]  width_reg;
    logic [CfgW-1:0]  height_reg;
    logic [PixW-1:0]  line_above [MaxWidth];
    logic [PixW-1:0]  line_two_above [MaxWidth];
    logic [PixW-1:0]  win [3][3];
    int unsigned      in_col;
    int unsigned      in_row;
    int unsigned      out_col;
    int unsigned      out_row;
    mean_result_t     expected_means [$];
    int unsigned      mismatches;

    function new();
      width_reg  = 11'd640;
      height_reg = 11'd480;
      foreach (line_above[i]) begin
        line_above[i]     = '0;
        line_two_above[i] = '0;
      end
      foreach (win[r, c]) win[r][c] = '0;
      clear_position();
      mismatches = 0;
    endfunction

    function void clear_position();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return 32'(height_reg);
    endfunction

    // Any register write restarts the frame
    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] value);
      case (idx)
        CfgImageWidth:  width_reg = value;
        CfgImageHeight: height_reg = value;
        default: ;
      endcase
      clear_position();
    endfunction

    function void take_pixel(logic [PixW-1:0] pixel, logic flush);
      int unsigned  w;
      int unsigned  h;
      int unsigned  x;
      int unsigned  sum;
      logic [PixW-1:0] px;
      logic [PixW-1:0] up;
      logic [PixW-1:0] up2;
      logic         emit;
      mean_result_t res;
      w = eff_width();
      h = eff_height();
      x = in_col;
      // Drop a flush that arrives before any pixel of the frame
      if (flush && in_row == 0 && in_col == 0) return;
      px  = (flush || in_row >= h) ? '0 : pixel;
      up  = (in_row >= 1) ? line_above[x] : '0;
      up2 = (in_row >= 2) ? line_two_above[x] : '0;
      line_two_above[x] = line_above[x];
      line_above[x]     = px;
      // Shift window left and load the new column
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = up2;
      win[1][2] = up;
      win[2][2] = px;
      emit = (in_row >= 2 || (in_row == 1 && x >= 1)) && out_row < h;
      // Advance input position, saturating below the image
      if (x + 1 >= w) begin
        in_col = 0;
        if (in_row < h + 2) in_row++;
      end else begin
        in_col = x + 1;
      end
      if (!emit) return;
      // Sum the neighborhood, leaving out columns beyond the row edges
      sum = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (c == 2 && x == 0) continue;
          if (c == 0 && (x == 1 || (x == 0 && w == 1))) continue;
          sum += 32'(win[r][c]);
        end
      end
      res.mean = PixW'(sum / 9);
      if (out_row + 1 >= h && out_col + 1 >= w) begin
        res.last = 1'b1;
        clear_position();
      end else begin
        res.last = 1'b0;
        if (out_col + 1 >= w) begin
          out_col = 0;
          out_row++;
        end else begin
          out_col++;
        end
      end
      expected_means.push_back(res);
    endfunction

    function void note_failure();
      mismatches++;
    endfunction

    function void check_mean(logic [PixW-1:0] mean, logic last);
      mean_result_t want;
      if (expected_means.size() == 0) begin
        if (mismatches < ReportLimit)
          $error("unexpected result: mean_value %0d frame_end %0b", mean, last);
        mismatches++;
        return;
      end
      want = expected_means.pop_front();
      if (mean !== want.mean) begin
        if (mismatches < ReportLimit)
          $error("mean_value mismatch: expected %0d, actual %0d", want.mean, mean);
        mismatches++;
      end
      if (last !== want.last) begin
        if (mismatches < ReportLimit)
          $error("frame_end mismatch: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [PixW-1:0]     m_axis_tdata;
  logic                m_axis_tlast;

  mean_tracker tracker = new();

  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  box_filter_3x3_zero_pad_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Accept results with random stalls; one long hold on request
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
      end else begin
        gap = sink_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      tracker.check_mean(m_axis_tdata, m_axis_tlast);
    end
  end

  // Offer one pixel transfer; entered and left at a falling edge
  task automatic send_item(input logic [PixW-1:0] pixel, input logic flush);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pixel;
    s_axis_tuser  <= flush;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.take_pixel(pixel, flush);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input idle until every predicted mean has arrived
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk_i);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.write_reg(idx, value);
    @(negedge clk_i);
  endtask

  // Send one frame: clean, with early flushes, with extra pixels, or cut short
  task automatic send_frame(input int unsigned kind);
    int unsigned w;
    int unsigned total;
    int unsigned extra;
    w = tracker.eff_width();
    total = w * tracker.eff_height();
    extra = 0;
    if (kind == 3) total = $urandom_range(1, total);
    for (int unsigned i = 0; i < total; i++)
      send_item(PixW'($urandom_range(0, 255)), (kind == 1) && ($urandom_range(0, 6) == 0));
    if (kind == 3) return;
    if (kind == 2) extra = $urandom_range(1, w + 1);
    for (int unsigned i = 0; i < extra; i++) send_item(PixW'($urandom_range(0, 255)), 1'b0);
    for (int unsigned i = 0; i < w + 1; i++) send_item(PixW'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    int unsigned phase;
    int unsigned base;
    int unsigned sel;
    int unsigned pick;
    int unsigned frames;
    int unsigned w_val;
    int unsigned h_val;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgImageWidth;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: 3x2 frame with a leading flush, an early flush and an extra pixel
    write_cfg(CfgImageWidth, 11'd3);
    write_cfg(CfgImageHeight, 11'd2);
    send_item(8'hA5, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hAA, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h55, 1'b0);
    for (int i = 0; i < 4; i++) send_item(8'hFF, 1'b1);
    wait_drained();

    // Directed: single-pixel frames at the pixel extremes
    write_cfg(CfgImageWidth, 11'd1);
    write_cfg(CfgImageHeight, 11'd1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b1);
    wait_drained();

    // Widest row, width above the limit, one row; stop a few flushes into the output
    write_cfg(CfgImageWidth, 11'd2047);
    write_cfg(CfgImageHeight, 11'd1);
    for (int unsigned i = 0; i < tracker.eff_width(); i++)
      send_item(PixW'($urandom_range(0, 255)), 1'b0);
    for (int i = 0; i < 4; i++) send_item(PixW'($urandom_range(0, 255)), 1'b1);
    wait_drained();

    // Random phases of small frames
    base = items_sent;
    phase = 0;
    while (items_sent - base < RandomItems) begin
      pick = $urandom_range(0, 99);
      w_val = (pick < 5) ? 0 : (pick < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      h_val = ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 6);
      sel = $urandom_range(0, 2);
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
        // Fill the block against a long output hold
        w_val = $urandom_range(10, 20);
        h_val = 6;
        sel = 2;
        src_idle = 1'b0;
      end
      if (sel != 1) write_cfg(CfgImageWidth, CfgW'(w_val));
      if (sel != 0) write_cfg(CfgImageHeight, CfgW'(h_val));
      if (phase == 0) long_hold_req = 1'b1;
      frames = $urandom_range(1, 3);
      for (int unsigned f = 0; f < frames; f++) begin
        pick = $urandom_range(0, 9);
        send_frame((phase == 0) ? 0 : (pick < 6) ? 0 : (pick < 8) ? 1 : (pick < 9) ? 2 : 3);
        if (phase == 1 && f == 0) wait_drained();
      end
      wait_drained();
      phase++;
    end

    repeat (20) @(negedge clk_i);
    if (tracker.pending() != 0) begin
      $error("%0d predicted results never arrived", tracker.pending());
      tracker.note_failure();
    end
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
